[src/sha256_pkg.sv]
// SHA-256 hasher package: round constants, initial hash values and shared types.
// Used by every module of the hasher; depends on nothing.
package sha256_pkg;

   localparam int unsigned BLOCK_BYTES = 64;
   localparam int unsigned LEN_POS     = 56;
   localparam logic [7:0]  PAD_BYTE    = 8'h80;

   // Item passed from the front (intake) to the back (compression engine)
   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       last;
   } cmd_type;

   typedef logic [31:0] word_type;

   function automatic word_type round_const(input logic [5:0] r);
      word_type k;
      case (r)
         6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491; 6'd2:  k = 32'hb5c0fbcf;
         6'd3:  k = 32'he9b5dba5; 6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5; 6'd8:  k = 32'hd807aa98;
         6'd9:  k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
         6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
         6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
         6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
         6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
         6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
         6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
         6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
         6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
         default: k = 32'hc67178f2;
      endcase
      return k;
   endfunction

   function automatic word_type init_hash(input logic [2:0] i);
      word_type h;
      case (i)
         3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
         3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
         3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
         3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
      endcase
      return h;
   endfunction

   function automatic word_type rotr(input word_type x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

endpackage

[src/sha256_byte_stream_hasher.sv]
// SHA-256 byte-stream hasher top level: intake queue feeding the compression engine.
// Depends on sha256_pkg, sha256_cmd_fifo and sha256_engine.
//
// Usage:
//   Input channel: one message byte per item (req_data_byte, req_byte_valid,
//   req_last); an item is taken when push is high and full is low.
//   An item with req_last high ends the message; byte_valid low with last
//   high hashes with no extra byte (empty message when nothing came before).
//   Result channel: eight digest words per message, word 0 first, on
//   rsp_digest_word with rsp_word_index and rsp_last_word; empty low
//   means a word is present, pop takes it.
//   Processing: every 64th byte starts a compression of 64 rounds, one per
//   cycle, in the shared round unit; the engine takes no item until it ends.
//   A last item costs a padding sweep plus one or two compressions, then
//   eight words.
//   The four-entry intake queue keeps accepting while the engine runs.
//   Reset: queues empty, hash state back to the initial values.
//   A stalled receiver holds the engine in its output phase; input queues up.
module sha256_byte_stream_hasher
   import sha256_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_valid,
   input  logic        req_last,
   output logic        empty,
   input  logic        pop,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   cmd_type in_cmd, q_cmd;
   logic    q_empty, q_take;

   assign in_cmd = '{data_byte: req_data_byte, byte_valid: req_byte_valid, last: req_last};

   sha256_cmd_fifo u_fifo (
      .clock, .reset,
      .push(push), .push_data(in_cmd), .full(full),
      .pop(q_take), .pop_data(q_cmd), .empty(q_empty)
   );

   sha256_engine u_engine (
      .clock, .reset,
      .cmd_avail(!q_empty), .cmd(q_cmd), .cmd_take(q_take),
      .out_word(rsp_digest_word), .out_index(rsp_word_index),
      .out_last(rsp_last_word), .out_empty(empty), .out_pop(pop)
   );

`ifndef SYNTHESIS
   // a last word is always word seven
   a_last_idx: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_last_word |-> rsp_word_index == 3'd7)
      else $error("last word index");
   // the engine only takes an item when the intake queue holds one
   a_queue_out: assert property (@(posedge clock) disable iff (reset)
      q_take |-> !q_empty)
      else $error("engine took from empty queue");
`endif

endmodule

[src/sha256_cmd_fifo.sv]
// Short item queue between the intake stage and the compression engine.
// Depends on sha256_pkg for the item type.
module sha256_cmd_fifo
   import sha256_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_data,
   output logic    empty
);

   localparam int unsigned DEPTH = 4;

   cmd_type     mem_ff [DEPTH];
   logic [1:0]  wr_ptr_ff, wr_ptr_in;
   logic [1:0]  rd_ptr_ff, rd_ptr_in;
   logic [2:0]  count_ff,  count_in;
   logic        do_push, do_pop;

   assign full     = (count_ff == 3'(DEPTH));
   assign empty    = (count_ff == 3'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 2'd1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 2'd1 : rd_ptr_ff;
      count_in  = count_ff + {2'b0, do_push} - {2'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[src/sha256_engine.sv]
// Back part of the hasher: block buffer, length count, padding and 64-round compression.
// Depends on sha256_pkg; emits digest words through a two-entry output queue.
module sha256_engine
   import sha256_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       cmd_avail,
   input  cmd_type    cmd,
   output logic       cmd_take,
   output logic [31:0] out_word,
   output logic [2:0] out_index,
   output logic       out_last,
   output logic       out_empty,
   input  logic       out_pop
);

   typedef enum logic [2:0] {
      S_IDLE, S_ROUND, S_PADFILL, S_LENFILL, S_EMIT
   } state_type;

   state_type   state_ff;
   // message block, four bytes per word, first byte in the top lane
   word_type    buf_ff [16];
   logic [63:0] count_ff;
   word_type    hash_ff [8];
   word_type    w_ff [16];
   word_type    v_ff [8];
   logic [5:0]  round_ff;
   logic [5:0]  fill_ff;
   logic        final_ff;
   logic [2:0]  emit_ff;

   // output queue, two entries
   word_type    oq_word_ff [2];
   logic [2:0]  oq_idx_ff [2];
   logic        oq_wr_ff, oq_rd_ff;
   logic [1:0]  oq_cnt_ff;
   logic        oq_push, oq_pop;

   assign out_empty = (oq_cnt_ff == 2'd0);
   assign out_word  = oq_word_ff[oq_rd_ff];
   assign out_index = oq_idx_ff[oq_rd_ff];
   assign out_last  = (oq_idx_ff[oq_rd_ff] == 3'd7);
   assign oq_pop    = out_pop && !out_empty;
   assign oq_push   = (state_ff == S_EMIT) && (oq_cnt_ff != 2'd2);
   assign cmd_take  = (state_ff == S_IDLE) && cmd_avail;

   // round datapath
   word_type wv, w15, w2, sig0, sig1, big0, big1, ch, maj, t1;
   logic [5:0] r;
   always_comb begin
      r    = round_ff;
      w15  = w_ff[4'(r - 6'd15)];
      w2   = w_ff[4'(r - 6'd2)];
      sig0 = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
      sig1 = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
      if (r < 6'd16) wv = w_ff[r[3:0]];
      else wv = w_ff[r[3:0]] + sig0 + w_ff[4'(r - 6'd7)] + sig1;
      big1 = rotr(v_ff[4], 6) ^ rotr(v_ff[4], 11) ^ rotr(v_ff[4], 25);
      ch   = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      t1   = v_ff[7] + big1 + ch + round_const(r) + wv;
      big0 = rotr(v_ff[0], 2) ^ rotr(v_ff[0], 13) ^ rotr(v_ff[0], 22);
      maj  = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
   end

   logic [5:0]  pos;
   logic [63:0] bits;
   assign pos  = count_ff[5:0];
   assign bits = {count_ff[60:0], 3'b000};

   // control sequencer and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         round_ff  <= '0;
         fill_ff   <= '0;
         final_ff  <= 1'b0;
         emit_ff   <= '0;
         for (int i = 0; i < 8; i++) hash_ff[i] <= init_hash(3'(i));
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (cmd_avail) begin
                  if (cmd.byte_valid) begin
                     buf_ff[pos[5:2]][{~pos[1:0], 3'b000} +: 8] <= cmd.data_byte;
                     count_ff    <= count_ff + 64'd1;
                     if (pos == 6'd63) begin
                        for (int j = 0; j < 15; j++) w_ff[j] <= buf_ff[j];
                        w_ff[15] <= {buf_ff[15][31:8], cmd.data_byte};
                        for (int j = 0; j < 8; j++) v_ff[j] <= hash_ff[j];
                        round_ff <= '0;
                        final_ff <= cmd.last;
                        state_ff <= S_ROUND;
                     end else if (cmd.last) begin
                        fill_ff  <= pos + 6'd1;
                        state_ff <= S_PADFILL;
                     end
                  end else if (cmd.last) begin
                     fill_ff  <= pos;
                     state_ff <= S_PADFILL;
                  end
               end
            end
            S_PADFILL: begin
               // write pad byte at the current position, zeros after it
               buf_ff[fill_ff[5:2]][{~fill_ff[1:0], 3'b000} +: 8] <=
                  (fill_ff == pos) ? PAD_BYTE : 8'h00;
               final_ff <= 1'b0;
               if (fill_ff == 6'd63) begin
                  // block overflows the length field: compress it first
                  for (int j = 0; j < 15; j++) w_ff[j] <= buf_ff[j];
                  w_ff[15] <= {buf_ff[15][31:8], (pos == 6'd63) ? PAD_BYTE : 8'h00};
                  for (int j = 0; j < 8; j++) v_ff[j] <= hash_ff[j];
                  round_ff <= '0;
                  state_ff <= S_ROUND;
               end else if (fill_ff == 6'd55) begin
                  fill_ff  <= '0;
                  state_ff <= S_LENFILL;
               end else begin
                  fill_ff <= fill_ff + 6'd1;
               end
            end
            S_LENFILL: begin
               // count up to the length field, then load the final block
               if (fill_ff < 6'(LEN_POS)) begin
                  fill_ff <= fill_ff + 6'd1;
               end
               if (fill_ff == 6'(LEN_POS)) begin
                  for (int j = 0; j < 14; j++) w_ff[j] <= buf_ff[j];
                  w_ff[14] <= bits[63:32];
                  w_ff[15] <= bits[31:0];
                  for (int j = 0; j < 8; j++) v_ff[j] <= hash_ff[j];
                  round_ff <= '0;
                  final_ff <= 1'b1;
                  fill_ff  <= 6'd63;
                  state_ff <= S_ROUND;
               end
            end
            S_ROUND: begin
               if (r >= 6'd16) w_ff[r[3:0]] <= wv;
               v_ff[7] <= v_ff[6];
               v_ff[6] <= v_ff[5];
               v_ff[5] <= v_ff[4];
               v_ff[4] <= v_ff[3] + t1;
               v_ff[3] <= v_ff[2];
               v_ff[2] <= v_ff[1];
               v_ff[1] <= v_ff[0];
               v_ff[0] <= t1 + big0 + maj;
               round_ff <= round_ff + 6'd1;
               if (round_ff == 6'd63) begin
                  hash_ff[0] <= hash_ff[0] + t1 + big0 + maj;
                  hash_ff[4] <= hash_ff[4] + v_ff[3] + t1;
                  hash_ff[1] <= hash_ff[1] + v_ff[0];
                  hash_ff[2] <= hash_ff[2] + v_ff[1];
                  hash_ff[3] <= hash_ff[3] + v_ff[2];
                  hash_ff[5] <= hash_ff[5] + v_ff[4];
                  hash_ff[6] <= hash_ff[6] + v_ff[5];
                  hash_ff[7] <= hash_ff[7] + v_ff[6];
                  if (final_ff && fill_ff == 6'd63) begin
                     emit_ff  <= '0;
                     state_ff <= S_EMIT;
                  end else if (final_ff || fill_ff == 6'd63) begin
                     // padding goes into a fresh block: zero it, pad byte
                     // only when the message ended on a block boundary
                     fill_ff  <= '0;
                     state_ff <= S_PADFILL;
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            S_EMIT: begin
               if (oq_push) begin
                  emit_ff <= emit_ff + 3'd1;
                  if (emit_ff == 3'd7) begin
                     for (int i = 0; i < 8; i++) hash_ff[i] <= init_hash(3'(i));
                     count_ff <= '0;
                     fill_ff  <= '0;
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // output queue
   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wr_ff  <= 1'b0;
         oq_rd_ff  <= 1'b0;
         oq_cnt_ff <= '0;
      end else begin
         if (oq_push) oq_wr_ff <= !oq_wr_ff;
         if (oq_pop)  oq_rd_ff <= !oq_rd_ff;
         oq_cnt_ff <= oq_cnt_ff + {1'b0, oq_push} - {1'b0, oq_pop};
      end
   end

   always_ff @(posedge clock) begin
      if (oq_push) begin
         oq_word_ff[oq_wr_ff] <= hash_ff[emit_ff];
         oq_idx_ff[oq_wr_ff]  <= emit_ff;
      end
   end

endmodule

[tb/sv/testbench.sv]
// Testbench for the SHA-256 byte-stream hasher: directed and random messages,
// digests predicted in-bench and checked word by word. Depends on sha256_pkg.
module testbench;
   import sha256_pkg::*;

   logic        clock;
   logic        reset;
   logic        push;
   logic        full;
   logic [7:0]  req_data_byte;
   logic        req_byte_valid;
   logic        req_last;
   logic        empty;
   logic        pop;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   typedef struct {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last_word;
   } digest_word_type;

   sha256_byte_stream_hasher dut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_data_byte(req_data_byte), .req_byte_valid(req_byte_valid),
      .req_last(req_last), .empty(empty), .pop(pop),
      .rsp_digest_word(rsp_digest_word), .rsp_word_index(rsp_word_index),
      .rsp_last_word(rsp_last_word)
   );

   // Predictor state
   logic [7:0]  msg_block [64];
   logic [63:0] msg_bytes;
   logic [31:0] hash_state [8];

   cmd_type         pending_items [$];
   digest_word_type expected_words [$];

   int errors = 0;
   int words_checked = 0;
   int digests_seen = 0;
   int items_sent = 0;
   int idle_cycles = 0;
   bit stim_done = 0;
   bit hold_rsp = 0;
   int hold_count = 0;
   int gap_left = 0;
   int pop_gap = 0;

   function automatic logic [31:0] ror(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic compress_msg_block();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2, s0, s1;
      for (int j = 0; j < 16; j++)
         w[j] = {msg_block[4*j], msg_block[4*j+1], msg_block[4*j+2], msg_block[4*j+3]};
      for (int j = 16; j < 64; j++) begin
         s0 = ror(w[j-15], 7) ^ ror(w[j-15], 18) ^ (w[j-15] >> 3);
         s1 = ror(w[j-2], 17) ^ ror(w[j-2], 19) ^ (w[j-2] >> 10);
         w[j] = w[j-16] + s0 + w[j-7] + s1;
      end
      for (int j = 0; j < 8; j++) v[j] = hash_state[j];
      for (int r = 0; r < 64; r++) begin
         t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
              + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_const(r[5:0]) + w[r];
         t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
              + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int j = 0; j < 8; j++) hash_state[j] += v[j];
   endtask

   task automatic restart_digest();
      for (int j = 0; j < 8; j++) hash_state[j] = init_hash(j[2:0]);
      msg_bytes = '0;
   endtask

   // Fold one accepted item into the running hash; on last, queue the digest
   task automatic hash_item(cmd_type it);
      int pos;
      logic [63:0] bit_len;
      digest_word_type dw;
      if (it.byte_valid) begin
         pos = int'(msg_bytes[5:0]);
         msg_block[pos] = it.data_byte;
         msg_bytes++;
         if (pos == 63) compress_msg_block();
      end
      if (!it.last) return;
      pos = int'(msg_bytes[5:0]);
      msg_block[pos] = PAD_BYTE;
      pos++;
      if (pos > LEN_POS) begin
         while (pos < BLOCK_BYTES) msg_block[pos++] = 8'h00;
         compress_msg_block();
         pos = 0;
      end
      while (pos < LEN_POS) msg_block[pos++] = 8'h00;
      bit_len = msg_bytes << 3;
      for (int j = 0; j < 8; j++) msg_block[LEN_POS + j] = bit_len[63 - 8*j -: 8];
      compress_msg_block();
      for (int j = 0; j < 8; j++) begin
         dw.word = hash_state[j];
         dw.index = j[2:0];
         dw.last_word = (j == 7);
         expected_words = {expected_words, dw};
      end
      restart_digest();
   endtask

   task automatic add_item(logic [7:0] b, logic v, logic l);
      cmd_type c;
      c.data_byte = b; c.byte_valid = v; c.last = l;
      pending_items = {pending_items, c};
   endtask

   // Whole message of n random bytes, optional byte on the last item
   task automatic add_message(int n);
      bit byte_on_last;
      byte_on_last = (n > 0) && $urandom_range(0, 1);
      for (int i = 0; i < n - byte_on_last; i++) begin
         if ($urandom_range(0, 19) == 0) add_item(8'($urandom), 1'b0, 1'b0);
         add_item(8'($urandom), 1'b1, 1'b0);
      end
      add_item(8'($urandom), byte_on_last, 1'b1);
   endtask

   function automatic int short_or_long_gap();
      if ($urandom_range(0, 2) == 0) return 0;
      if ($urandom_range(0, 15) == 0) return $urandom_range(10, 60);
      return $urandom_range(0, 3);
   endfunction

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Driver: offers queued items, random gaps between them
   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
         req_data_byte <= '0;
         req_byte_valid <= 1'b0;
         req_last <= 1'b0;
      end else begin
         if (push && !full) begin
            hash_item(pending_items.pop_front());
            items_sent++;
            gap_left = short_or_long_gap();
         end
         if (!(push && full)) begin
            if (gap_left > 0) begin
               gap_left--;
               push <= 1'b0;
            end else if (pending_items.size() > 0 && !stim_done) begin
               push <= 1'b1;
               req_data_byte <= pending_items[0].data_byte;
               req_byte_valid <= pending_items[0].byte_valid;
               req_last <= pending_items[0].last;
            end else begin
               push <= 1'b0;
            end
         end
      end
   end

   // Monitor: takes digest words, random stalls plus a long hold-off
   always @(posedge clock) begin
      digest_word_type want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            words_checked++;
            if (rsp_last_word) digests_seen++;
            if (expected_words.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: unexpected word %h index %0d",
                           rsp_digest_word, rsp_word_index);
            end else begin
               want = expected_words.pop_front();
               if (rsp_digest_word !== want.word || rsp_word_index !== want.index ||
                   rsp_last_word !== want.last_word) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: expected %h/%0d/%0d got %h/%0d/%0d",
                              want.word, want.index, want.last_word,
                              rsp_digest_word, rsp_word_index, rsp_last_word);
               end
            end
         end
         if (hold_rsp) begin
            pop <= 1'b0;
            if (hold_count > 0) hold_count--;
            else hold_rsp = 0;
         end else if (pop_gap > 0) begin
            pop_gap--;
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
            if (!empty && $urandom_range(0, 3) == 0) pop_gap = short_or_long_gap();
         end
      end
   end

   // Watchdog on cycles with no accepted item on either side
   always @(posedge clock) begin
      if (!reset) begin
         if ((push && !full) || (pop && !empty)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= 20000) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin
      int n;
      reset = 1'b1;
      restart_digest();
      for (int j = 0; j < 64; j++) msg_block[j] = 8'h00;
      // Directed: empty message, neither-flag items, byte on last, extreme bytes
      add_item(8'hff, 1'b0, 1'b0);
      add_item(8'h00, 1'b0, 1'b1);
      add_item(8'h00, 1'b1, 1'b1);
      add_item(8'hff, 1'b1, 1'b0);
      add_item(8'h55, 1'b0, 1'b0);
      add_item(8'haa, 1'b1, 1'b1);
      add_item(8'h61, 1'b1, 1'b0);
      add_item(8'h62, 1'b1, 1'b0);
      add_item(8'h63, 1'b0, 1'b1);
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      // Wait for directed part to drain
      wait (pending_items.size() == 0 && expected_words.size() == 0);
      // Padding boundaries: 55, 56, 63, 64 byte messages
      add_message(55);
      add_message(56);
      add_message(63);
      add_message(64);
      // Long receiver hold-off while the sender keeps pushing
      @(posedge clock);
      hold_count = 400;
      hold_rsp = 1;
      add_message(9);
      add_message(3);
      add_message(0);
      add_message(5);
      wait (hold_rsp == 0);
      // Sender pauses until every digest word has arrived
      wait (pending_items.size() == 0 && expected_words.size() == 0);
      // Random messages, mostly short, a few across block boundaries
      while (pending_items.size() + items_sent < 380) begin
         if ($urandom_range(0, 9) == 0) n = $urandom_range(50, 130);
         else n = $urandom_range(0, 20);
         add_message(n);
         if ($urandom_range(0, 7) == 0) add_item(8'($urandom), 1'b0, 1'b0);
      end
      wait (pending_items.size() == 0 && expected_words.size() == 0);
      repeat (300) @(posedge clock);
      $display("covered %0d items, %0d digests, %0d words checked",
               items_sent, digests_seen, words_checked);
      $display("incl. empty message, byte on last, padding boundaries, stalls");
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

[filelist.f]
src/sha256_pkg.sv
src/sha256_cmd_fifo.sv
src/sha256_engine.sv
src/sha256_byte_stream_hasher.sv
tb/sv/testbench.sv
